### hdl/sar_pkg.sv
// Shared types and constants for the suffix array interval refiner.
// No dependencies; imported by sar_probe and the top level.
package sar_pkg;

   localparam int unsigned TEXT_DEPTH_DEF = 65536;
   localparam int unsigned SA_DEPTH_DEF   = 65536;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_WRITE_TEXT = 2'd0;
   localparam logic [1:0] REQ_WRITE_SA   = 2'd1;
   localparam logic [1:0] REQ_REFINE     = 2'd2;

   // store write request from the sequencer to the probe unit
   typedef struct packed {
      logic        text_we;
      logic        sa_we;
      logic [15:0] address;
      logic [7:0]  text_byte;
      logic [15:0] suffix_pos;
   } sar_write_type;

   // probe result: pattern char compared against the suffix char
   typedef struct packed {
      logic done;
      logic lt;   // pattern char below suffix char
      logic eq;   // pattern char equals suffix char
   } sar_probe_result_type;

endpackage

### hdl/sar_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module sar_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sar_probe.sv
// Character probe unit: suffix store read, text store read, byte compare.
// Owns both stores. Depends on sar_pkg and sar_ram.
module sar_probe #(
   parameter int unsigned TEXT_DEPTH = sar_pkg::TEXT_DEPTH_DEF,
   parameter int unsigned SA_DEPTH   = sar_pkg::SA_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sar_pkg::sar_write_type        wr,
   input  logic                          start,
   input  logic [15:0]                   sa_index,
   input  logic [15:0]                   depth,
   input  logic [7:0]                    pattern_char,
   output sar_pkg::sar_probe_result_type result
);
   import sar_pkg::*;

   localparam int unsigned TEXT_AW = $clog2(TEXT_DEPTH);
   localparam int unsigned SA_AW   = $clog2(SA_DEPTH);

   logic               phase1_ff, phase1_in;
   logic               phase2_ff, phase2_in;
   logic [31:0]        wr_addr_ext;
   logic [31:0]        probe_idx_ext;
   logic [31:0]        text_addr_ext;
   logic [16:0]        text_sum;
   logic [SA_AW-1:0]   sa_addr;
   logic [TEXT_AW-1:0] text_addr;
   logic [15:0]        sa_rdata;
   logic [7:0]         text_rdata;

   // stores are power-of-two deep, so indexes wrap by dropping high bits
   assign wr_addr_ext   = {16'd0, wr.address};
   assign probe_idx_ext = {16'd0, sa_index};
   assign text_sum      = {1'b0, sa_rdata} + {1'b0, depth};
   assign text_addr_ext = {15'd0, text_sum};

   assign sa_addr   = wr.sa_we   ? wr_addr_ext[SA_AW-1:0]   : probe_idx_ext[SA_AW-1:0];
   assign text_addr = wr.text_we ? wr_addr_ext[TEXT_AW-1:0] : text_addr_ext[TEXT_AW-1:0];

   sar_ram #(.WIDTH(16), .DEPTH(SA_DEPTH)) u_sa_store (
      .clock   (clock),
      .wr_en   (wr.sa_we),
      .addr    (sa_addr),
      .wr_data (wr.suffix_pos),
      .rd_data (sa_rdata)
   );

   sar_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text_store (
      .clock   (clock),
      .wr_en   (wr.text_we),
      .addr    (text_addr),
      .wr_data (wr.text_byte),
      .rd_data (text_rdata)
   );

   assign phase1_in = start;
   assign phase2_in = phase1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase1_ff <= 1'b0;
         phase2_ff <= 1'b0;
      end else begin
         phase1_ff <= phase1_in;
         phase2_ff <= phase2_in;
      end
   end

   assign result.done = phase2_ff;
   assign result.lt   = pattern_char < text_rdata;
   assign result.eq   = pattern_char == text_rdata;

endmodule

### hdl/suffix_array_interval_refiner.sv
// Top level of the suffix array interval refiner: handshake and search sequencer.
// Depends on sar_pkg and sar_probe (which holds the text and suffix stores).
//
// Usage:
//  - req channel: req_tuser picks the item kind (write text byte, write suffix
//    array entry, refine interval); req_tdata carries all other fields.
//  - Write items are taken while idle and give no result. Every store entry
//    must be written before a refine item reads it.
//  - A refine item narrows [lo_bound, hi_bound] to the suffixes whose char at
//    match_depth equals pattern_char and returns one item on rsp.
//  - Each char probe runs suffix store read, text store read and compare
//    through the single probe unit; a reversed interval answers without
//    any probe.
//  - One item at a time: req_tready is high only while the sequencer is idle.
//  - The result is held in registers with rsp_tvalid high until rsp_tready;
//    a stalled receiver stalls the block, nothing is lost.
//  - Reset (synchronous) returns the sequencer to idle and drops rsp_tvalid.
//    Store contents are not cleared; no clearing pass is run.
//  - TEXT_DEPTH and SA_DEPTH must be powers of two; indexes wrap modulo depth.
module suffix_array_interval_refiner #(
   parameter int unsigned TEXT_DEPTH = sar_pkg::TEXT_DEPTH_DEF,
   parameter int unsigned SA_DEPTH   = sar_pkg::SA_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tuser: req_type[1:0]
   input  logic [1:0]  req_tuser,
   // req_tdata: address[15:0], text_byte[23:16], suffix_pos[39:24],
   //            pattern_char[47:40], match_depth[63:48], lo_bound[79:64],
   //            hi_bound[95:80]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata: new_lo[16:0], new_hi[32:17], found[33], zero pad[39:34]
   output logic [39:0] rsp_tdata
);
   import sar_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIRST = 3'd1;  // probing lo_bound
   localparam logic [2:0] ST_LAST  = 3'd2;  // probing hi_bound
   localparam logic [2:0] ST_LTEST = 3'd3;  // left border loop test
   localparam logic [2:0] ST_LWAIT = 3'd4;
   localparam logic [2:0] ST_RTEST = 3'd5;  // right border loop test
   localparam logic [2:0] ST_RWAIT = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [7:0]  char_ff, char_in;
   logic [15:0] depth_ff, depth_in;
   logic [15:0] lo_ff, lo_in;
   logic [15:0] hi_ff, hi_in;
   logic [16:0] left_ff, left_in;
   logic [15:0] right_ff, right_in;
   logic [15:0] rl_ff, rl_in;
   logic [15:0] rr_ff, rr_in;
   logic [15:0] mid_ff, mid_in;
   logic        hit_ff, hit_in;
   logic        first_lt_ff, first_lt_in;
   logic        first_eq_ff, first_eq_in;
   logic        last_eq_ff, last_eq_in;

   logic        req_accept;
   logic [1:0]  f_type;
   logic [15:0] f_address;
   logic [7:0]  f_text_byte;
   logic [15:0] f_suffix_pos;
   logic [7:0]  f_pattern_char;
   logic [15:0] f_match_depth;
   logic [15:0] f_lo_bound;
   logic [15:0] f_hi_bound;

   sar_write_type        wr;
   sar_probe_result_type probe;
   logic                 probe_start;
   logic [15:0]          probe_index;

   logic [16:0] lsum;
   logic [16:0] rsum;
   logic        lmore;
   logic        rmore;
   logic        found;

   assign f_type         = req_tuser;
   assign f_address      = req_tdata[15:0];
   assign f_text_byte    = req_tdata[23:16];
   assign f_suffix_pos   = req_tdata[39:24];
   assign f_pattern_char = req_tdata[47:40];
   assign f_match_depth  = req_tdata[63:48];
   assign f_lo_bound     = req_tdata[79:64];
   assign f_hi_bound     = req_tdata[95:80];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // writes only happen in idle, so they never collide with a probe
   assign wr.text_we    = req_accept && (f_type == REQ_WRITE_TEXT);
   assign wr.sa_we      = req_accept && (f_type == REQ_WRITE_SA);
   assign wr.address    = f_address;
   assign wr.text_byte  = f_text_byte;
   assign wr.suffix_pos = f_suffix_pos;

   sar_probe #(.TEXT_DEPTH(TEXT_DEPTH), .SA_DEPTH(SA_DEPTH)) u_probe (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .start        (probe_start),
      .sa_index     (probe_index),
      .depth        (depth_ff),
      .pattern_char (char_ff),
      .result       (probe)
   );

   // search loop tests; left stays below 2^16 inside the loop
   assign lsum  = {1'b0, right_ff} + left_ff;
   assign rsum  = {1'b0, rl_ff} + {1'b0, rr_ff};
   assign lmore = {1'b0, right_ff} > (left_ff + 17'd1);
   assign rmore = {1'b0, rr_ff} > ({1'b0, rl_ff} + 17'd1);

   always_comb begin
      state_in    = state_ff;
      char_in     = char_ff;
      depth_in    = depth_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      rl_in       = rl_ff;
      rr_in       = rr_ff;
      mid_in      = mid_ff;
      hit_in      = hit_ff;
      first_lt_in = first_lt_ff;
      first_eq_in = first_eq_ff;
      last_eq_in  = last_eq_ff;
      probe_start = 1'b0;
      probe_index = mid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (f_type == REQ_REFINE)) begin
               char_in  = f_pattern_char;
               depth_in = f_match_depth;
               lo_in    = f_lo_bound;
               hi_in    = f_hi_bound;
               hit_in   = 1'b0;
               if (f_hi_bound < f_lo_bound) begin
                  // reversed interval: echo the bounds, not found
                  left_in  = {1'b0, f_lo_bound};
                  rl_in    = f_hi_bound;
                  state_in = ST_OUT;
               end else begin
                  probe_start = 1'b1;
                  probe_index = f_lo_bound;
                  state_in    = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            if (probe.done) begin
               first_lt_in = probe.lt;
               first_eq_in = probe.eq;
               probe_start = 1'b1;
               probe_index = hi_ff;
               state_in    = ST_LAST;
            end
         end
         ST_LAST: begin
            if (probe.done) begin
               last_eq_in = probe.eq;
               if (first_lt_ff) begin
                  // char sorts before the whole interval
                  left_in  = {1'b0, lo_ff} + 17'd1;
                  rl_in    = lo_ff;
                  state_in = ST_OUT;
               end else if (!probe.lt && !probe.eq) begin
                  // char sorts after the whole interval
                  left_in  = {1'b0, hi_ff} + 17'd1;
                  rl_in    = hi_ff;
                  state_in = ST_OUT;
               end else begin
                  left_in  = {1'b0, lo_ff};
                  right_in = hi_ff;
                  rl_in    = lo_ff;
                  rr_in    = hi_ff;
                  if (first_eq_ff) begin
                     // left border is lo itself
                     hit_in = 1'b1;
                     if (probe.eq) begin
                        rl_in    = hi_ff;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_RTEST;
                     end
                  end else begin
                     state_in = ST_LTEST;
                  end
               end
            end
         end
         ST_LTEST: begin
            if (lmore) begin
               mid_in      = lsum[16:1];
               probe_start = 1'b1;
               probe_index = lsum[16:1];
               state_in    = ST_LWAIT;
            end else begin
               left_in = {1'b0, right_ff};
               if (!hit_ff) begin
                  rl_in = right_ff - 16'd1;
               end
               if (last_eq_ff) begin
                  rl_in    = hi_ff;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_RTEST;
               end
            end
         end
         ST_LWAIT: begin
            if (probe.done) begin
               if (probe.lt || probe.eq) begin
                  // first match seen bounds the right search
                  if (!hit_ff && probe.eq) begin
                     hit_in = 1'b1;
                     rl_in  = mid_ff;
                     rr_in  = right_ff;
                  end
                  right_in = mid_ff;
               end else begin
                  left_in = {1'b0, mid_ff};
               end
               state_in = ST_LTEST;
            end
         end
         ST_RTEST: begin
            if (rmore) begin
               mid_in      = rsum[16:1];
               probe_start = 1'b1;
               probe_index = rsum[16:1];
               state_in    = ST_RWAIT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RWAIT: begin
            if (probe.done) begin
               if (probe.lt) begin
                  rr_in = mid_ff;
               end else begin
                  rl_in = mid_ff;
               end
               state_in = ST_RTEST;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      depth_ff    <= depth_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      rl_ff       <= rl_in;
      rr_ff       <= rr_in;
      mid_ff      <= mid_in;
      first_lt_ff <= first_lt_in;
      first_eq_ff <= first_eq_in;
      last_eq_ff  <= last_eq_in;
   end

   assign found      = left_ff <= {1'b0, rl_ff};
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {6'd0, found, rl_ff, left_ff};

endmodule
